@@ hdl/ps2kbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ps2kbd_pkg;

   localparam logic [7:0] CMD_SET_LEDS    = 8'hED;
   localparam logic [7:0] CMD_ECHO        = 8'hEE;
   localparam logic [7:0] CMD_SCAN_SET    = 8'hF0;
   localparam logic [7:0] CMD_READ_ID     = 8'hF2;
   localparam logic [7:0] CMD_TYPEMATIC   = 8'hF3;
   localparam logic [7:0] CMD_ENABLE      = 8'hF4;
   localparam logic [7:0] CMD_DISABLE     = 8'hF5;
   localparam logic [7:0] CMD_DEFAULTS    = 8'hF6;
   localparam logic [7:0] CMD_ALL_TYPE    = 8'hF7;
   localparam logic [7:0] CMD_ALL_MAKE_BRK = 8'hF8;
   localparam logic [7:0] CMD_ALL_MAKE    = 8'hF9;
   localparam logic [7:0] CMD_ALL_TYP_BRK = 8'hFA;
   localparam logic [7:0] CMD_KEY_TYPE    = 8'hFB;
   localparam logic [7:0] CMD_KEY_MAKE_BRK = 8'hFC;
   localparam logic [7:0] CMD_KEY_MAKE    = 8'hFD;
   localparam logic [7:0] CMD_RESET       = 8'hFF;

   localparam logic [7:0] RSP_ACK    = 8'hFA;
   localparam logic [7:0] RSP_ECHO   = 8'hEE;
   localparam logic [7:0] RSP_ID0    = 8'hAB;
   localparam logic [7:0] RSP_ID1    = 8'h83;
   localparam logic [7:0] RSP_RESEND = 8'hFE;

   localparam logic [1:0]  SET_RESET    = 2'd2;
   localparam logic [18:0] PERIOD_RESET = 19'd91743;
   localparam logic [9:0]  DELAY_RESET  = 10'd500;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_LEDS = 2'd1,
      PEND_SET  = 2'd2,
      PEND_RATE = 2'd3
   } pend_type;

   typedef enum logic [2:0] {
      NOTE_NONE     = 3'd0,
      NOTE_LEDS     = 3'd1,
      NOTE_SET      = 3'd2,
      NOTE_ENABLED  = 3'd3,
      NOTE_DISABLED = 3'd4
   } note_type;

   localparam logic [18:0] PERIOD_TABLE [32] = '{
      19'd33333,  19'd37453,  19'd41667,  19'd45872,
      19'd48309,  19'd54054,  19'd58480,  19'd62500,
      19'd66667,  19'd75188,  19'd83333,  19'd91743,
      19'd100000, 19'd108696, 19'd116279, 19'd125000,
      19'd133333, 19'd149254, 19'd166667, 19'd181818,
      19'd200000, 19'd217391, 19'd232558, 19'd250000,
      19'd270270, 19'd303030, 19'd333333, 19'd370370,
      19'd400000, 19'd434783, 19'd476190, 19'd500000
   };

   localparam logic [9:0] DELAY_TABLE [4] = '{10'd250, 10'd500, 10'd750, 10'd1000};

endpackage

`default_nettype wire

@@ hdl/ps2_keyboard_host_command_unit_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Word
// req_      in         req_valid / req_ready  one host byte
// rsp_      out        rsp_valid / rsp_ready  one response byte with current settings
//
// A host byte is registered, then decoded into a result register once that is free,
// holding one to three response bytes; those leave one per cycle while rsp_ready is high.
// The response port sets the pace, and a new byte is taken while the previous one is answered.
// Synchronous reset restores the power-on settings.
// A stalled response port holds the result register and then the input register.

module ps2_keyboard_host_command_unit_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_host_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_response_byte,
   output logic             rsp_last_response,
   output logic [2:0]       rsp_led_state,
   output logic [1:0]       rsp_active_set,
   output logic             rsp_keys_enabled,
   output logic [18:0]      rsp_repeat_period_us,
   output logic [9:0]       rsp_repeat_delay_ms,
   output logic             rsp_restart_self_test,
   output logic [2:0]       rsp_notify_kind,
   output logic [2:0]       rsp_notify_value
);
   import ps2kbd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   pend_type    pend_ff, pend_in;
   logic        collect_ff, collect_in;
   logic [1:0]  set_ff, set_in;
   logic [2:0]  led_ff, led_in;
   logic        enable_ff, enable_in;
   logic [18:0] period_ff, period_in;
   logic [9:0]  delay_ff, delay_in;

   logic        res_valid_ff;
   logic [7:0]  res_byte_ff [3];
   logic [7:0]  res_byte_in [3];
   logic [1:0]  res_last_ff, res_last_in;
   logic [1:0]  res_idx_ff;
   logic        res_restart_ff, res_restart_in;
   note_type    res_kind_ff, res_kind_in;
   logic [2:0]  res_value_ff, res_value_in;

   logic        res_done;
   logic        load;
   logic [7:0]  b;

   assign res_done  = rsp_ready && (res_idx_ff == res_last_ff);
   assign load      = in_valid_ff && (!res_valid_ff || res_done);
   assign req_ready = !in_valid_ff || load;
   assign b         = in_byte_ff;

   always_comb begin
      pend_in        = pend_ff;
      collect_in     = collect_ff;
      set_in         = set_ff;
      led_in         = led_ff;
      enable_in      = enable_ff;
      period_in      = period_ff;
      delay_in       = delay_ff;
      res_byte_in[0] = RSP_ACK;
      res_byte_in[1] = RSP_ID0;
      res_byte_in[2] = RSP_ID1;
      res_last_in    = 2'd0;
      res_restart_in = 1'b0;
      res_kind_in    = NOTE_NONE;
      res_value_in   = 3'd0;

      if (collect_ff && (b < CMD_SET_LEDS)) begin
         // A scancode in a set-3 key list is acknowledged.
         res_byte_in[0] = RSP_ACK;
      end else begin
         collect_in = 1'b0;
         if (pend_ff != PEND_NONE) begin
            pend_in = PEND_NONE;
            case (pend_ff)
               PEND_LEDS: begin
                  led_in       = b[2:0];
                  res_kind_in  = NOTE_LEDS;
                  res_value_in = b[2:0];
               end
               PEND_RATE: begin
                  period_in = PERIOD_TABLE[b[4:0]];
                  delay_in  = DELAY_TABLE[b[6:5]];
               end
               default: begin
                  if (b == 8'd0) begin
                     res_byte_in[1] = {6'd0, set_ff};
                     res_last_in    = 2'd1;
                  end else if (b <= 8'd3) begin
                     set_in       = b[1:0];
                     res_kind_in  = NOTE_SET;
                     res_value_in = {1'b0, b[1:0]};
                  end
               end
            endcase
         end else begin
            unique case (b)
               CMD_RESET, CMD_DEFAULTS: begin
                  pend_in        = PEND_NONE;
                  collect_in     = 1'b0;
                  set_in         = SET_RESET;
                  led_in         = 3'd0;
                  enable_in      = 1'b1;
                  period_in      = PERIOD_RESET;
                  delay_in       = DELAY_RESET;
                  res_kind_in    = NOTE_LEDS;
                  res_restart_in = (b == CMD_RESET);
               end
               CMD_ECHO: res_byte_in[0] = RSP_ECHO;
               CMD_READ_ID: res_last_in = 2'd2;
               CMD_SET_LEDS: pend_in = PEND_LEDS;
               CMD_SCAN_SET: pend_in = PEND_SET;
               CMD_TYPEMATIC: pend_in = PEND_RATE;
               CMD_ENABLE: begin
                  enable_in    = 1'b1;
                  res_kind_in  = NOTE_ENABLED;
                  res_value_in = 3'd1;
               end
               CMD_DISABLE: begin
                  enable_in   = 1'b0;
                  res_kind_in = NOTE_DISABLED;
               end
               CMD_ALL_TYPE, CMD_ALL_MAKE_BRK, CMD_ALL_MAKE, CMD_ALL_TYP_BRK: begin
                  res_byte_in[0] = RSP_ACK;
               end
               CMD_KEY_TYPE, CMD_KEY_MAKE_BRK, CMD_KEY_MAKE: collect_in = 1'b1;
               default: res_byte_in[0] = RSP_RESEND;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         res_idx_ff   <= 2'd0;
         pend_ff      <= PEND_NONE;
         collect_ff   <= 1'b0;
         set_ff       <= SET_RESET;
         led_ff       <= 3'd0;
         enable_ff    <= 1'b1;
         period_ff    <= PERIOD_RESET;
         delay_ff     <= DELAY_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            res_valid_ff <= 1'b1;
            res_idx_ff   <= 2'd0;
            pend_ff      <= pend_in;
            collect_ff   <= collect_in;
            set_ff       <= set_in;
            led_ff       <= led_in;
            enable_ff    <= enable_in;
            period_ff    <= period_in;
            delay_ff     <= delay_in;
         end else if (res_valid_ff && rsp_ready) begin
            if (res_done) begin
               res_valid_ff <= 1'b0;
            end else begin
               res_idx_ff <= res_idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_host_byte;
      end
      if (load) begin
         res_byte_ff    <= res_byte_in;
         res_last_ff    <= res_last_in;
         res_restart_ff <= res_restart_in;
         res_kind_ff    <= res_kind_in;
         res_value_ff   <= res_value_in;
      end
   end

   assign rsp_valid             = res_valid_ff;
   assign rsp_response_byte     = res_byte_ff[res_idx_ff];
   assign rsp_last_response     = (res_idx_ff == res_last_ff);
   assign rsp_led_state         = led_ff;
   assign rsp_active_set        = set_ff;
   assign rsp_keys_enabled      = enable_ff;
   assign rsp_repeat_period_us  = period_ff;
   assign rsp_repeat_delay_ms   = delay_ff;
   assign rsp_restart_self_test = res_restart_ff;
   assign rsp_notify_kind       = res_kind_ff;
   assign rsp_notify_value      = res_value_ff;

endmodule

`default_nettype wire
